/* rtl/core/assert_macros.svh */
// Assertion macros shared by the encoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on a clock edge, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but also evaluated during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/rftpe_pkg.sv */
// Types, constants and the code word builder for the tri-state pulse encoder.
// No dependencies; imported by every module of the block.
package rftpe_pkg;

   localparam int unsigned UNIT_W    = 16;
   localparam int unsigned REPEAT_W  = 8;
   localparam int unsigned PULSES    = 24;
   localparam int unsigned PATTERN_W = 24;

   localparam logic [UNIT_W-1:0]   UNIT_TICKS_RESET   = 16'd350;
   localparam logic [REPEAT_W-1:0] REPEAT_TOTAL_RESET = 8'd10;

   // Pulse 24 is the sync pulse.
   localparam logic [4:0] SYNC_INDEX     = 5'(PULSES);
   localparam logic [4:0] SHORT_UNITS    = 5'd1;
   localparam logic [4:0] LONG_UNITS     = 5'd3;
   localparam logic [4:0] SYNC_LOW_UNITS = 5'd31;

   typedef enum logic {
      CSR_UNIT_TICKS   = 1'b0,
      CSR_REPEAT_TOTAL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [UNIT_W-1:0]   unit_ticks;    // zero already mapped to one
      logic [REPEAT_W-1:0] repeat_total;  // zero already mapped to one
   } cfg_type;

   typedef struct packed {
      logic       operation;
      logic [4:0] address_bits;
      logic [1:0] channel_index;
      logic       switch_on;
   } item_type;

   typedef struct packed {
      logic rejected;
      logic busy_res;
      logic tx_level;
   } result_type;

   // Bit h set means pulse h is long. Symbol F = short then long, symbol 0 = two shorts.
   function automatic logic [PATTERN_W-1:0] build_pattern(input logic [4:0] addr,
                                                          input logic [1:0] chan,
                                                          input logic       on);
      logic [PATTERN_W-1:0] pat;
      pat = '0;
      for (int s = 0; s < 5; s++) begin
         pat[2*s+1]    = ~addr[4-s];
         pat[2*s+11]   = (3'(s) != {1'b0, chan});
      end
      pat[21] = ~on;
      pat[23] = on;
      return pat;
   endfunction

endpackage

/* rtl/core/rftpe_csr.sv */
// Configuration registers of the pulse encoder: unit length and repeat count.
// Depends on rftpe_pkg.
module rftpe_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [rftpe_pkg::UNIT_W-1:0]    csr_wdata,
   output rftpe_pkg::cfg_type              cfg
);
   import rftpe_pkg::*;

   logic [UNIT_W-1:0]   unit_ticks_ff, unit_ticks_in;
   logic [REPEAT_W-1:0] repeat_total_ff, repeat_total_in;

   always_comb begin
      unit_ticks_in   = unit_ticks_ff;
      repeat_total_in = repeat_total_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_UNIT_TICKS:   unit_ticks_in   = csr_wdata;
            CSR_REPEAT_TOTAL: repeat_total_in = csr_wdata[REPEAT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff   <= UNIT_TICKS_RESET;
         repeat_total_ff <= REPEAT_TOTAL_RESET;
      end else begin
         unit_ticks_ff   <= unit_ticks_in;
         repeat_total_ff <= repeat_total_in;
      end
   end

   assign cfg.unit_ticks   = (unit_ticks_ff == '0) ? UNIT_W'(1) : unit_ticks_ff;
   assign cfg.repeat_total = (repeat_total_ff == '0) ? REPEAT_W'(1) : repeat_total_ff;

endmodule

/* rtl/core/rftpe_engine.sv */
// Transmit sequencer: pulse, phase, unit, tick and repeat counters of the encoder.
// Depends on rftpe_pkg and assert_macros.svh.
module rftpe_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  rftpe_pkg::item_type    item,
   input  rftpe_pkg::cfg_type     cfg,
   output rftpe_pkg::result_type  result
);
   import rftpe_pkg::*;
   `include "assert_macros.svh"

   logic [PATTERN_W-1:0] half_pattern_ff, half_pattern_in;
   logic [4:0]           half_index_ff, half_index_in;
   logic                 high_phase_ff, high_phase_in;
   logic [4:0]           unit_count_ff, unit_count_in;
   logic [UNIT_W-1:0]    tick_count_ff, tick_count_in;
   logic [REPEAT_W-1:0]  repeat_count_ff, repeat_count_in;
   logic                 active_ff, active_in;
   logic                 rej;

   logic [31:0]         pattern_ext;
   logic                is_long;
   logic [4:0]          phase_len;
   logic [UNIT_W-1:0]   tick_inc;
   logic [4:0]          unit_inc;
   logic [4:0]          half_inc;
   logic [REPEAT_W-1:0] repeat_inc;

   // Length of the running phase in units.
   always_comb begin
      pattern_ext = {{(32-PATTERN_W){1'b0}}, half_pattern_ff};
      is_long     = pattern_ext[half_index_ff];
      if (half_index_ff >= SYNC_INDEX) begin
         phase_len = high_phase_ff ? SHORT_UNITS : SYNC_LOW_UNITS;
      end else if (high_phase_ff) begin
         phase_len = is_long ? LONG_UNITS : SHORT_UNITS;
      end else begin
         phase_len = is_long ? SHORT_UNITS : LONG_UNITS;
      end
   end

   assign tick_inc   = tick_count_ff + UNIT_W'(1);
   assign unit_inc   = unit_count_ff + 5'd1;
   assign half_inc   = half_index_ff + 5'd1;
   assign repeat_inc = repeat_count_ff + REPEAT_W'(1);

   always_comb begin
      half_pattern_in = half_pattern_ff;
      half_index_in   = half_index_ff;
      high_phase_in   = high_phase_ff;
      unit_count_in   = unit_count_ff;
      tick_count_in   = tick_count_ff;
      repeat_count_in = repeat_count_ff;
      active_in       = active_ff;
      rej             = 1'b0;
      if (step_en) begin
         if (item.operation) begin
            if (active_ff) begin
               rej = 1'b1;
            end else begin
               half_pattern_in = build_pattern(item.address_bits, item.channel_index,
                                               item.switch_on);
               half_index_in   = '0;
               high_phase_in   = 1'b1;
               unit_count_in   = '0;
               tick_count_in   = '0;
               repeat_count_in = '0;
               active_in       = 1'b1;
            end
         end else if (active_ff) begin
            tick_count_in = tick_inc;
            if (tick_inc >= cfg.unit_ticks) begin
               tick_count_in = '0;
               unit_count_in = unit_inc;
               if (unit_inc >= phase_len) begin
                  unit_count_in = '0;
                  if (high_phase_ff) begin
                     high_phase_in = 1'b0;
                  end else begin
                     half_index_in = half_inc;
                     high_phase_in = 1'b1;
                     if (half_inc > SYNC_INDEX) begin
                        half_index_in   = '0;
                        repeat_count_in = repeat_inc;
                        if (repeat_inc >= cfg.repeat_total) begin
                           active_in       = 1'b0;
                           repeat_count_in = '0;
                           high_phase_in   = 1'b0;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_pattern_ff <= '0;
         half_index_ff   <= '0;
         high_phase_ff   <= 1'b0;
         unit_count_ff   <= '0;
         tick_count_ff   <= '0;
         repeat_count_ff <= '0;
         active_ff       <= 1'b0;
      end else begin
         half_pattern_ff <= half_pattern_in;
         half_index_ff   <= half_index_in;
         high_phase_ff   <= high_phase_in;
         unit_count_ff   <= unit_count_in;
         tick_count_ff   <= tick_count_in;
         repeat_count_ff <= repeat_count_in;
         active_ff       <= active_in;
      end
   end

   assign result.tx_level = active_in & high_phase_in;
   assign result.busy_res = active_in;
   assign result.rejected = rej;

   `ASSERT_CLK(a_idle_line_low, clock, reset, !active_ff |-> !high_phase_ff,
      "high phase flagged while idle")
   `ASSERT_CLK(a_index_range, clock, reset, half_index_ff <= SYNC_INDEX,
      "pulse index past sync")
   `ASSERT_CLK(a_start_loads, clock, reset,
      (step_en && item.operation && !active_ff) |=>
         (active_ff && high_phase_ff && half_index_ff == '0 && repeat_count_ff == '0),
      "command while idle did not start a transmission")

endmodule

/* rtl/core/rf_remote_tristate_pulse_encoder_core.sv */
// Top level of the tri-state RF remote pulse encoder: input and result registers.
// Depends on rftpe_pkg, rftpe_csr, rftpe_engine and assert_macros.svh.
//
//   channel | direction | payload
//   req_    | in        | tuser: operation; tdata: address_bits, channel_index, switch_on
//   rsp_    | out       | tdata: tx_level, busy_res, rejected
//   csr_    | in        | write enable, index, 16-bit data
//
// One word per clock cycle sustained while rsp_tready stays high; a word passes the input
// register, then the result register, before its result word is valid on rsp.
// The counter update between the two registers is the only per-word work.
// Reset is synchronous: encoder idle, line low, unit_ticks 350, repeat_total 10.
// A stalled rsp holds its word; the input register still takes a word, then
// req_tready drops until rsp drains.
module rf_remote_tristate_pulse_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] address_bits, [6:5] channel_index, [7] switch_on
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] tx_level, [1] busy_res, [2] rejected, [7:3] zero
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import rftpe_pkg::*;
   `include "assert_macros.svh"

   cfg_type    cfg;
   item_type   in_item_ff, in_item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type rsp_word_ff, rsp_word_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       step_en;
   logic       req_fire;

   assign step_en    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in              = 1'b1;
         in_item_in.operation     = req_tuser;
         in_item_in.address_bits  = req_tdata[4:0];
         in_item_in.channel_index = req_tdata[6:5];
         in_item_in.switch_on     = req_tdata[7];
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (step_en) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_word_ff <= rsp_word_in;
   end

   rftpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rftpe_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_word_ff.rejected, rsp_word_ff.busy_res,
                        rsp_word_ff.tx_level};

   `ASSERT_CLK(a_reject_only_busy, clock, reset,
      rsp_valid_ff && rsp_word_ff.rejected |-> rsp_word_ff.busy_res,
      "rejected word without busy")
   `ASSERT_CLK(a_line_needs_busy, clock, reset,
      rsp_valid_ff && rsp_word_ff.tx_level |-> rsp_word_ff.busy_res,
      "line high while idle")
   `ASSERT_CLK(a_stall_holds_input, clock, reset,
      (in_valid_ff && !step_en) |=> (in_valid_ff && $stable(in_item_ff)),
      "input word lost during result stall")

endmodule

/* verif/rf_remote_tristate_pulse_encoder_core_tb.sv */
// Self-checking testbench for rf_remote_tristate_pulse_encoder_core.
// Drives command/tick words, predicts the transmit line word by word, checks rsp.
// Depends on rftpe_pkg and the encoder RTL.
`timescale 1ns / 100ps

module rf_remote_tristate_pulse_encoder_core_tb;
   import rftpe_pkg::*;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_COMMAND = 1'b1;

   typedef enum logic {
      ROW_WORD,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      item_type      word;
      csr_index_type sel;
      logic [15:0]   value;
      logic          known;
      result_type    want;   // {rejected, busy_res, tx_level}
   } plan_row_type;

   localparam int PLAN_ROWS = 26;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // tick while idle, then start, then a command while busy
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b1, 3'b000},
      '{ROW_WORD, '{OP_COMMAND, 5'd31, 2'd0, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b1, 3'b011},
      '{ROW_WORD, '{OP_COMMAND, 5'd0,  2'd3, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b1, 3'b111},
      '{ROW_WORD, '{OP_TICK,    5'd31, 2'd3, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b1, 3'b011},
      // zero unit length mid-word: the running tick count already meets it
      '{ROW_CSR,  '0,                               CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd1, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_CSR,  '0,                               CSR_REPEAT_TOTAL, 16'hFFFF,  1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd1,  2'd2, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd2,  2'd3, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd4,  2'd0, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd8,  2'd1, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd16, 2'd2, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd31, 2'd3, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_CSR,  '0,                               CSR_UNIT_TICKS,   16'hFFFF,  1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd31, 2'd1, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_COMMAND, 5'd21, 2'd2, 1'b1}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd10, 2'd3, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_CSR,  '0,                               CSR_UNIT_TICKS,   16'd2,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      // zero repeat count mid-word: treated as one
      '{ROW_CSR,  '0,                               CSR_REPEAT_TOTAL, 16'hAB00,  1'b0, '0},
      '{ROW_WORD, '{OP_COMMAND, 5'd21, 2'd1, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0},
      '{ROW_WORD, '{OP_TICK,    5'd0,  2'd0, 1'b0}, CSR_UNIT_TICKS,   16'd0,     1'b0, '0}
   };

   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS   = 280;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // predicted encoder state and registers
   logic [UNIT_W-1:0]    cfg_unit_ticks;
   logic [REPEAT_W-1:0]  cfg_repeat_total;
   logic [PATTERN_W-1:0] enc_pattern;
   logic [4:0]           enc_pulse;
   logic                 enc_high;
   logic [4:0]           enc_units;
   logic [15:0]          enc_ticks;
   logic [7:0]           enc_reps;
   logic                 enc_active;

   result_type due_line_reports[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int words_checked;
   int bursts_done;
   int busy_rejects;
   logic last_busy;

   rf_remote_tristate_pulse_encoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   // bit 2s+1 set when symbol s is F (second pulse long)
   function automatic logic [PATTERN_W-1:0] code_pattern(logic [4:0] addr, logic [1:0] chan,
                                                        logic on);
      logic [11:0]          f_sym;
      logic [PATTERN_W-1:0] pat;
      for (int s = 0; s < 5; s++) begin
         f_sym[s]     = ~addr[4-s];
         f_sym[5 + s] = (s != chan);
      end
      f_sym[10] = ~on;
      f_sym[11] = on;
      pat = '0;
      for (int s = 0; s < 12; s++)
         pat[2*s+1] = f_sym[s];
      return pat;
   endfunction

   function automatic logic [4:0] pulse_units();
      logic is_long;
      if (enc_pulse >= SYNC_INDEX)
         return enc_high ? SHORT_UNITS : SYNC_LOW_UNITS;
      is_long = enc_pattern[enc_pulse];
      if (enc_high)
         return is_long ? LONG_UNITS : SHORT_UNITS;
      return is_long ? SHORT_UNITS : LONG_UNITS;
   endfunction

   function automatic void advance_pulse_timer();
      logic [UNIT_W-1:0]   unit_len;
      logic [REPEAT_W-1:0] rep_len;
      unit_len = (cfg_unit_ticks == '0) ? UNIT_W'(1) : cfg_unit_ticks;
      rep_len  = (cfg_repeat_total == '0) ? REPEAT_W'(1) : cfg_repeat_total;
      enc_ticks = enc_ticks + 16'd1;
      if (enc_ticks < unit_len)
         return;
      enc_ticks = '0;
      enc_units = enc_units + 5'd1;
      if (enc_units < pulse_units())
         return;
      enc_units = '0;
      if (enc_high) begin
         enc_high = 1'b0;
         return;
      end
      enc_pulse = enc_pulse + 5'd1;
      if (enc_pulse > SYNC_INDEX) begin
         enc_pulse = '0;
         enc_reps  = enc_reps + 8'd1;
         if (enc_reps >= rep_len) begin
            enc_active = 1'b0;
            enc_reps   = '0;
         end
      end
      enc_high = enc_active;
   endfunction

   function automatic result_type encoder_step(item_type w);
      result_type r;
      r = '0;
      if (w.operation == OP_COMMAND) begin
         if (enc_active) begin
            r.rejected = 1'b1;
         end else begin
            enc_pattern = code_pattern(w.address_bits, w.channel_index, w.switch_on);
            enc_pulse   = '0;
            enc_high    = 1'b1;
            enc_units   = '0;
            enc_ticks   = '0;
            enc_reps    = '0;
            enc_active  = 1'b1;
         end
      end else if (enc_active) begin
         advance_pulse_timer();
      end
      r.tx_level = enc_active & enc_high;
      r.busy_res = enc_active;
      return r;
   endfunction

   task automatic send_word(item_type w, logic known, result_type typed);
      result_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.operation;
      req_tdata  <= {w.switch_on, w.channel_index, w.address_bits};
      do
         @(posedge clock);
      while (!req_tready);
      predicted = encoder_step(w);
      due_line_reports.push_back(known ? typed : predicted);
   endtask

   task automatic hold_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // registers change only once every word has come back
   task automatic write_csr(csr_index_type sel, logic [15:0] value);
      hold_req();
      while (due_line_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_UNIT_TICKS)
         cfg_unit_ticks = value;
      else
         cfg_repeat_total = value[REPEAT_W-1:0];
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[2:0];
         if (due_line_reports.size() == 0) begin
            $error("rsp word with nothing expected: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = due_line_reports.pop_front();
            words_checked++;
            if (got.tx_level !== want.tx_level) begin
               $error("tx_level expected %0d got %0d", want.tx_level, got.tx_level);
               error_count++;
            end
            if (got.busy_res !== want.busy_res) begin
               $error("busy_res expected %0d got %0d", want.busy_res, got.busy_res);
               error_count++;
            end
            if (got.rejected !== want.rejected) begin
               $error("rejected expected %0d got %0d", want.rejected, got.rejected);
               error_count++;
            end
            if (rsp_tdata[7:3] !== 5'd0) begin
               $error("tdata pad expected 0 got %0h", rsp_tdata[7:3]);
               error_count++;
            end
            if (last_busy && !got.busy_res)
               bursts_done++;
            if (got.rejected)
               busy_rejects++;
            last_busy = got.busy_res;
         end
      end
   end

   initial begin
      item_type w;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= OP_TICK;
      csr_we        <= 1'b0;
      csr_index     <= CSR_UNIT_TICKS;
      csr_wdata     <= '0;
      send_idle_pct = 24;
      recv_idle_pct = 46;
      error_count   = 0;
      words_checked = 0;
      bursts_done   = 0;
      busy_rejects  = 0;
      last_busy     = 1'b0;

      cfg_unit_ticks   = UNIT_TICKS_RESET;
      cfg_repeat_total = REPEAT_TOTAL_RESET;
      enc_pattern = '0;
      enc_pulse   = '0;
      enc_high    = 1'b0;
      enc_units   = '0;
      enc_ticks   = '0;
      enc_reps    = '0;
      enc_active  = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CSR)
            write_csr(PLAN[i].sel, PLAN[i].value);
         else
            send_word(PLAN[i].word, PLAN[i].known, PLAN[i].want);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph / 2)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // mostly one tick per unit and a single burst so that bursts finish often
         write_csr(CSR_UNIT_TICKS,
                   ($urandom_range(0, 99) < 60) ? 16'd1 : 16'($urandom_range(0, 3)));
         write_csr(CSR_REPEAT_TOTAL, {8'($urandom),
                   ($urandom_range(0, 99) < 60) ? 8'd1 : 8'($urandom_range(0, 2))});
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (enc_active)
               w.operation = ($urandom_range(0, 99) < 3) ? OP_COMMAND : OP_TICK;
            else
               w.operation = ($urandom_range(0, 99) < 60) ? OP_COMMAND : OP_TICK;
            w.address_bits  = 5'($urandom);
            w.channel_index = 2'($urandom);
            w.switch_on     = 1'($urandom);
            send_word(w, 1'b0, '0);
         end
      end

      hold_req();
      while (due_line_reports.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Checked %0d rsp words: %0d bursts ran to idle, %0d commands refused while busy.",
               words_checked, bursts_done, busy_rejects);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
